/* hw/rtl/pre_pkg.sv */
// ----------------------------------------------------------------------------
// pre_pkg
// Shared types, constants and helpers of the edge-aware Poisson RHS block.
// ----------------------------------------------------------------------------
`default_nettype none
package pre_pkg;
  localparam int MaxWidth = 1024;
  localparam int AddrW    = $clog2(MaxWidth);
  localparam int PixW     = 49;
  localparam int SqW      = 20;
  localparam int SumW     = 22;
  localparam int RadW     = 38;
  localparam int RootW    = 19;

  localparam logic [1:0] CfgWidth   = 2'd0;
  localparam logic [1:0] CfgThresh  = 2'd1;
  localparam logic [1:0] CfgChannel = 2'd2;

  localparam logic ImgGuide = 1'b0;
  localparam logic ImgUnder = 1'b1;

  typedef logic [PixW-1:0] pix_t;
  typedef pix_t [2:0][2:0] win_t;

  typedef struct packed {
    logic             upd;
    logic [AddrW-1:0] col;
    logic [AddrW-1:0] row;
  } wstat_t;

  typedef enum logic [3:0] {
    S_IDLE, S_WAIT, S_CHECK, S_NBR, S_SQ, S_SUM,
    S_RA_GO, S_RA_WAIT, S_RB_GO, S_RB_WAIT, S_CMP, S_EMIT
  } state_e;

  function automatic logic [7:0] pick(input pix_t p, input logic img, input logic [1:0] ch);
    logic [23:0] part;
    part = (img == ImgUnder) ? p[48:25] : p[24:1];
    case (ch)
      2'd0:    pick = part[7:0];
      2'd1:    pick = part[15:8];
      default: pick = part[23:16];
    endcase
  endfunction
endpackage
`default_nettype wire

/* hw/rtl/pre_sqrt.sv */
// ----------------------------------------------------------------------------
// pre_sqrt
// Iterative integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pre_sqrt (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start_i,
  input  wire  [pre_pkg::RadW-1:0]   rad_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [pre_pkg::RootW-1:0]  root_o
);
  localparam int CntW = $clog2(pre_pkg::RootW + 1);

  logic [pre_pkg::RadW-1:0]  rad_q, rad_d;
  logic [pre_pkg::RootW+1:0] rem_q, rem_d;
  logic [pre_pkg::RootW-1:0] root_q, root_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic                      busy_q, busy_d, done_q, done_d;
  logic [pre_pkg::RootW+3:0] rem_n, trial;

  always_comb begin
    rem_n  = {rem_q, rad_q[pre_pkg::RadW-1 -: 2]};
    trial  = {2'b00, root_q, 2'b01};
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CntW'(pre_pkg::RootW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = rad_q << 2;
      if (rem_n >= trial) begin
        rem_d  = (pre_pkg::RootW + 2)'(rem_n - trial);
        root_d = {root_q[pre_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_d  = (pre_pkg::RootW + 2)'(rem_n);
        root_d = {root_q[pre_pkg::RootW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = root_q;
endmodule
`default_nettype wire

/* hw/rtl/pre_window.sv */
// ----------------------------------------------------------------------------
// pre_window
// Line store memory, 3x3 window registers and raster position counters.
// ----------------------------------------------------------------------------
`default_nettype none
module pre_window (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  pix_req_i,
  input  wire                  frame_start_i,
  input  pre_pkg::pix_t        pix_i,
  input  wire  [10:0]          width_i,
  output pre_pkg::wstat_t      stat_o,
  output pre_pkg::win_t        win_o
);
  localparam int AW = pre_pkg::AddrW;

  logic [2*pre_pkg::PixW-1:0] mem [pre_pkg::MaxWidth];
  logic [2*pre_pkg::PixW-1:0] rd_q;
  pre_pkg::pix_t              cur_q;
  pre_pkg::win_t              win_q;
  logic [AW-1:0]              col_q, col_d, row_q, row_d, pcol_q, prow_q;
  logic [AW-1:0]              col, row;
  logic                       pend_q, upd_q;

  always_comb begin
    col   = frame_start_i ? '0 : col_q;
    row   = frame_start_i ? '0 : row_q;
    col_d = col_q;
    row_d = row_q;
    if (pix_req_i) begin
      if ({1'b0, col} + 11'd1 >= width_i) begin
        col_d = '0;
        row_d = row + 1'b1;
      end else begin
        col_d = col + 1'b1;
        row_d = row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      pend_q <= 1'b0;
      upd_q  <= 1'b0;
      win_q  <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      pend_q <= pix_req_i;
      upd_q  <= pend_q;
      if (pend_q) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r][0] <= win_q[r][1];
          win_q[r][1] <= win_q[r][2];
        end
        win_q[0][2] <= rd_q[2*pre_pkg::PixW-1:pre_pkg::PixW];
        win_q[1][2] <= rd_q[pre_pkg::PixW-1:0];
        win_q[2][2] <= cur_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_req_i) begin
      rd_q   <= mem[col];
      cur_q  <= pix_i;
      pcol_q <= col;
      prow_q <= row;
    end
    if (pend_q) begin
      mem[pcol_q] <= {rd_q[pre_pkg::PixW-1:0], cur_q};
    end
  end

  assign stat_o = '{upd: upd_q, col: pcol_q, row: prow_q};
  assign win_o  = win_q;
endmodule
`default_nettype wire

/* hw/rtl/poisson_rhs_edge_aware.sv */
// ----------------------------------------------------------------------------
// poisson_rhs_edge_aware
// Edge-aware Poisson blending right-hand side over a raster pixel stream.
// ----------------------------------------------------------------------------
// Slave channel: one pixel per request, tuser flags the first pixel of a
// frame, tdata carries the mask bit and the guide and under RGB bytes.
// Master channel: one result per masked pixel whose 3x3 window lies fully
// inside the frame; it is the centre of the window one row and one column
// behind the last accepted pixel.
// When no result is due, a pixel passes the line store read, window shift and
// check. A masked centre then visits each neighbour in turn: a masked one is
// skipped, an unmasked one goes through square, sum and compare around two
// 19-step passes of the shared square root unit.
// The result waits in an output register; a new pixel is accepted while it
// waits, and the block holds before loading the next result until it is taken.
// Reset clears the window, counters and configuration (width 640, threshold
// 2560, channel 0); the line store needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module poisson_rhs_edge_aware (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [55:0] s_axis_tdata,   // in_mask, guide_c0..c2, under_c0..c2, zero pad
  input  wire         s_axis_tuser,   // frame_start
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_x, out_y, rhs_value
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_idx_i,
  input  wire  [18:0] cfg_data_i
);
  pre_pkg::state_e state_q, state_d;
  pre_pkg::wstat_t stat;
  pre_pkg::win_t   w;
  pre_pkg::pix_t   nb [3], ce [3], npx;

  logic [10:0] fw_q, width;
  logic [18:0] thr_q;
  logic [1:0]  chs_q, ch, k_q;
  logic        pix_req, emit, sq_start, sq_busy, sq_done, out_load, last_k;
  logic [pre_pkg::RootW-1:0] root, ra_q, rb_q;
  logic [pre_pkg::SqW-1:0]   sq_q [6];
  logic [pre_pkg::SumW-1:0]  sa_q, sb_q;
  logic [3:0]  guide_q;
  logic [31:0] out_q;
  logic        out_valid_q;
  logic [12:0] v;
  logic [20:0] thr3;
  logic [pre_pkg::RadW-1:0] rad;

  assign width = (fw_q < 11'd3) ? 11'd3 :
                 (fw_q > 11'(pre_pkg::MaxWidth)) ? 11'(pre_pkg::MaxWidth) : fw_q;
  assign ch    = (chs_q > 2'd2) ? 2'd2 : chs_q;
  assign thr3  = {1'b0, thr_q, 1'b0} + {2'b00, thr_q};
  assign rad   = (state_q == pre_pkg::S_RA_GO) ? {sa_q, 16'd0} : {sb_q, 16'd0};
  assign last_k = (k_q == 2'd3);

  pre_window u_window (
    .clk_i, .rst_ni,
    .pix_req_i    (pix_req),
    .frame_start_i(s_axis_tuser),
    .pix_i        (s_axis_tdata[pre_pkg::PixW-1:0]),
    .width_i      (width),
    .stat_o       (stat),
    .win_o        (w)
  );

  pre_sqrt u_sqrt (
    .clk_i, .rst_ni,
    .start_i(sq_start),
    .rad_i  (rad),
    .busy_o (sq_busy),
    .done_o (sq_done),
    .root_o (root)
  );

  assign emit = (stat.col >= 2) && (stat.row >= 2) && w[1][1][0];

  always_comb begin
    case (k_q)
      2'd0: begin
        nb = '{w[0][0], w[0][1], w[0][2]};
        ce = '{w[1][0], w[1][1], w[1][2]};
        npx = w[0][1];
      end
      2'd1: begin
        nb = '{w[0][0], w[1][0], w[2][0]};
        ce = '{w[0][1], w[1][1], w[2][1]};
        npx = w[1][0];
      end
      2'd2: begin
        nb = '{w[0][2], w[1][2], w[2][2]};
        ce = '{w[0][1], w[1][1], w[2][1]};
        npx = w[1][2];
      end
      default: begin
        nb = '{w[2][0], w[2][1], w[2][2]};
        ce = '{w[1][0], w[1][1], w[1][2]};
        npx = w[2][1];
      end
    endcase
  end

  logic [pre_pkg::SqW-1:0] sq_d [6];
  always_comb begin
    logic [9:0]  sc, sn;
    logic [10:0] d;
    logic [21:0] p;
    for (int i = 0; i < 6; i++) begin
      sc = 10'(pre_pkg::pick(ce[0], 1'(i / 3), 2'(i % 3))) +
           {1'b0, pre_pkg::pick(ce[1], 1'(i / 3), 2'(i % 3)), 1'b0} +
           10'(pre_pkg::pick(ce[2], 1'(i / 3), 2'(i % 3)));
      sn = 10'(pre_pkg::pick(nb[0], 1'(i / 3), 2'(i % 3))) +
           {1'b0, pre_pkg::pick(nb[1], 1'(i / 3), 2'(i % 3)), 1'b0} +
           10'(pre_pkg::pick(nb[2], 1'(i / 3), 2'(i % 3)));
      d = {1'b0, sc} - {1'b0, sn};
      p = 22'($signed(d) * $signed(d));
      sq_d[i] = p[pre_pkg::SqW-1:0];
    end
  end

  always_comb begin
    pre_pkg::pix_t np [4];
    logic [12:0] g;
    np = '{w[0][1], w[1][0], w[1][2], w[2][1]};
    v = -13'({3'b000, pre_pkg::pick(w[1][1], pre_pkg::ImgGuide, ch), 2'b00});
    for (int i = 0; i < 4; i++) begin
      g = 13'(pre_pkg::pick(np[i], pre_pkg::ImgGuide, ch));
      v = v + g;
      if (!np[i][0]) begin
        v = v - (guide_q[i] ? g : 13'(pre_pkg::pick(np[i], pre_pkg::ImgUnder, ch)));
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pre_pkg::S_IDLE:    if (s_axis_tvalid) state_d = pre_pkg::S_WAIT;
      pre_pkg::S_WAIT:    if (stat.upd) state_d = pre_pkg::S_CHECK;
      pre_pkg::S_CHECK:   state_d = emit ? pre_pkg::S_NBR : pre_pkg::S_IDLE;
      pre_pkg::S_NBR:     if (!npx[0]) state_d = pre_pkg::S_SQ;
                          else if (last_k) state_d = pre_pkg::S_EMIT;
      pre_pkg::S_SQ:      state_d = pre_pkg::S_SUM;
      pre_pkg::S_SUM:     state_d = pre_pkg::S_RA_GO;
      pre_pkg::S_RA_GO:   state_d = pre_pkg::S_RA_WAIT;
      pre_pkg::S_RA_WAIT: if (sq_done) state_d = pre_pkg::S_RB_GO;
      pre_pkg::S_RB_GO:   state_d = pre_pkg::S_RB_WAIT;
      pre_pkg::S_RB_WAIT: if (sq_done) state_d = pre_pkg::S_CMP;
      pre_pkg::S_CMP:     state_d = last_k ? pre_pkg::S_EMIT : pre_pkg::S_NBR;
      pre_pkg::S_EMIT:    if (!out_valid_q || m_axis_tready) state_d = pre_pkg::S_IDLE;
      default:            state_d = pre_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == pre_pkg::S_IDLE);
    sq_start      = (state_q == pre_pkg::S_RA_GO) || (state_q == pre_pkg::S_RB_GO);
    out_load      = (state_q == pre_pkg::S_EMIT) && (!out_valid_q || m_axis_tready);
  end
  assign pix_req = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pre_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      fw_q        <= 11'd640;
      thr_q       <= 19'd2560;
      chs_q       <= 2'd0;
      k_q         <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pre_pkg::CfgWidth:   fw_q  <= cfg_data_i[10:0];
          pre_pkg::CfgThresh:  thr_q <= cfg_data_i;
          pre_pkg::CfgChannel: chs_q <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (state_q == pre_pkg::S_CHECK) k_q <= '0;
      else if ((state_q == pre_pkg::S_NBR && npx[0] && !last_k) ||
               (state_q == pre_pkg::S_CMP && !last_k)) k_q <= k_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == pre_pkg::S_SQ) sq_q <= sq_d;
    if (state_q == pre_pkg::S_SUM) begin
      sa_q <= pre_pkg::SumW'(sq_q[0]) + pre_pkg::SumW'(sq_q[1]) + pre_pkg::SumW'(sq_q[2]);
      sb_q <= pre_pkg::SumW'(sq_q[3]) + pre_pkg::SumW'(sq_q[4]) + pre_pkg::SumW'(sq_q[5]);
    end
    if (state_q == pre_pkg::S_RA_WAIT && sq_done) ra_q <= root;
    if (state_q == pre_pkg::S_RB_WAIT && sq_done) rb_q <= root;
    if (state_q == pre_pkg::S_CMP)
      guide_q[k_q] <= (21'(ra_q) + 21'(rb_q)) >= thr3;
    if (out_load)
      out_q <= {v[11:0], stat.row - 1'b1, stat.col - 1'b1};
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTHESIS
  a_sqrt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_start |-> !sq_busy) else $error("root unit restarted while busy");
  a_upd_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.upd |-> state_q == pre_pkg::S_WAIT) else $error("window update out of step");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q || m_axis_tready) else $error("result overwritten");
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_req |=> state_q == pre_pkg::S_WAIT) else $error("pixel accept lost");
`endif
endmodule
`default_nettype wire
